// ----- hdl/vtr_pkg.sv -----
// Shared types and constants of the two-axis vertex rotator.
package vtr_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int TRIG_LATENCY = CORDIC_STEPS + 2;
	localparam int TRIG_WAIT_WIDTH = $clog2(TRIG_LATENCY + 1);

	localparam int ANGLE_WIDTH = 16;
	localparam int ANGLE_SHIFT = 16;
	localparam int LANE_WIDTH = 33;
	localparam int PHASE_WIDTH = 34;

	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = 16;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

	localparam logic signed [LANE_WIDTH-1:0] CORDIC_GAIN_START = 33'sd652032874;
	localparam logic signed [PHASE_WIDTH-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [PHASE_WIDTH-1:0] HALF_TURN = 34'sd2147483648;

	localparam logic signed [PHASE_WIDTH-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
		34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
		34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81,
		34'sd41, 34'sd20, 34'sd10, 34'sd5,
		34'sd3, 34'sd1
	};

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ANGLE_X   = 2'd0,
		REG_ANGLE_Y   = 2'd1,
		REG_ROTATE_EN = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [LANE_WIDTH-1:0]  x;
		logic signed [LANE_WIDTH-1:0]  y;
		logic signed [PHASE_WIDTH-1:0] z;
		logic                          flip;
	} cordic_lane_t;

	typedef struct packed {
		cordic_lane_t ax;
		cordic_lane_t ay;
	} cordic_pair_t;

endpackage

// ----- hdl/vtr_ifs.sv -----
// Vertex and result channel interfaces.
interface vtr_vertex_if #(parameter int COORD_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic                          object_last;

	modport source (output valid, coord_x, coord_y, coord_z, object_last, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, object_last, output ready);
endinterface

interface vtr_result_if #(parameter int COORD_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rot_x;
	logic signed [COORD_WIDTH-1:0] rot_y;
	logic signed [COORD_WIDTH-1:0] rot_z;
	logic                          object_last_out;

	modport source (output valid, rot_x, rot_y, rot_z, object_last_out, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, object_last_out, output ready);
endinterface

// ----- hdl/vtr_cordic_cell.sv -----
// One CORDIC rotation step for both angle lanes, registered.
module vtr_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                  clk,
	input  vtr_pkg::cordic_pair_t d,
	output vtr_pkg::cordic_pair_t q
);
	import vtr_pkg::*;

	function automatic cordic_lane_t iterate(input cordic_lane_t l);
		cordic_lane_t r;
		logic signed [LANE_WIDTH-1:0] dx;
		logic signed [LANE_WIDTH-1:0] dy;
		dx = $signed(l.y) >>> STEP;
		dy = $signed(l.x) >>> STEP;
		r = l;
		if (!l.z[PHASE_WIDTH-1]) begin
			r.x = l.x - dx;
			r.y = l.y + dy;
			r.z = l.z - ATAN_TAB[STEP];
		end else begin
			r.x = l.x + dx;
			r.y = l.y - dy;
			r.z = l.z + ATAN_TAB[STEP];
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		q.ax <= iterate(d.ax);
		q.ay <= iterate(d.ay);
	end

endmodule

// ----- hdl/vtr_trig_chain.sv -----
// Sine and cosine of both rotation angles through a chain of CORDIC cells.
module vtr_trig_chain #(
	parameter int TRIG_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic signed [vtr_pkg::ANGLE_WIDTH-1:0]   angle_x,
	input  logic signed [vtr_pkg::ANGLE_WIDTH-1:0]   angle_y,
	output logic signed [TRIG_WIDTH-1:0]             cos_x,
	output logic signed [TRIG_WIDTH-1:0]             sin_x,
	output logic signed [TRIG_WIDTH-1:0]             cos_y,
	output logic signed [TRIG_WIDTH-1:0]             sin_y
);
	import vtr_pkg::*;

	localparam int SHIFT = 32 - TRIG_WIDTH;
	localparam int OUT_W = LANE_WIDTH + 1 - SHIFT;
	localparam logic signed [LANE_WIDTH:0] RND_T = (LANE_WIDTH + 1)'(1) << (SHIFT - 1);
	localparam logic signed [OUT_W-1:0] ONE_T = OUT_W'(1) << (TRIG_WIDTH - 2);

	cordic_pair_t fold_s1;
	cordic_pair_t link [CORDIC_STEPS];

	function automatic cordic_lane_t fold(input logic signed [ANGLE_WIDTH-1:0] a);
		cordic_lane_t l;
		logic signed [PHASE_WIDTH-1:0] z;
		z = {{(PHASE_WIDTH - ANGLE_WIDTH - ANGLE_SHIFT){a[ANGLE_WIDTH-1]}}, a,
			{ANGLE_SHIFT{1'b0}}};
		l.x = CORDIC_GAIN_START;
		l.y = '0;
		l.z = z;
		l.flip = 1'b0;
		if (z > QUARTER_TURN) begin
			l.z = z - HALF_TURN;
			l.flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			l.z = z + HALF_TURN;
			l.flip = 1'b1;
		end
		return l;
	endfunction

	function automatic logic signed [TRIG_WIDTH-1:0] finish(
		input cordic_lane_t l,
		input logic         take_y
	);
		logic signed [LANE_WIDTH:0] v;
		logic signed [OUT_W-1:0] r;
		v = take_y ? (LANE_WIDTH + 1)'(l.y) : (LANE_WIDTH + 1)'(l.x);
		if (l.flip) begin
			v = -v;
		end
		v = v + RND_T;
		r = OUT_W'(v >>> SHIFT);
		if (r > ONE_T) begin
			r = ONE_T;
		end else if (r < -ONE_T) begin
			r = -ONE_T;
		end
		return TRIG_WIDTH'(r);
	endfunction

	always_ff @(posedge clk) begin
		fold_s1.ax <= fold(angle_x);
		fold_s1.ay <= fold(angle_y);
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		if (g == 0) begin : g_head
			vtr_cordic_cell #(.STEP(g)) u_cell (.clk(clk), .d(fold_s1), .q(link[g]));
		end else begin : g_body
			vtr_cordic_cell #(.STEP(g)) u_cell (.clk(clk), .d(link[g-1]), .q(link[g]));
		end
	end

	always_ff @(posedge clk) begin
		cos_x <= finish(link[CORDIC_STEPS-1].ax, 1'b0);
		sin_x <= finish(link[CORDIC_STEPS-1].ax, 1'b1);
		cos_y <= finish(link[CORDIC_STEPS-1].ay, 1'b0);
		sin_y <= finish(link[CORDIC_STEPS-1].ay, 1'b1);
	end

endmodule

// ----- hdl/vtr_vertex_pipe.sv -----
// Four-stage rotate datapath: X-axis products, X-axis sums, Y-axis products, Y-axis sums.
module vtr_vertex_pipe #(
	parameter int COORD_WIDTH = 16,
	parameter int TRIG_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic signed [COORD_WIDTH-1:0] in_z,
	input  logic                          in_last,
	input  logic signed [TRIG_WIDTH-1:0]  cos_x,
	input  logic signed [TRIG_WIDTH-1:0]  sin_x,
	input  logic signed [TRIG_WIDTH-1:0]  cos_y,
	input  logic signed [TRIG_WIDTH-1:0]  sin_y,
	input  logic                          rotate_en,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                          out_last
);
	localparam int FB  = TRIG_WIDTH - 2;
	localparam int P1  = COORD_WIDTH + TRIG_WIDTH;
	localparam int S1  = P1 + 1;
	localparam int Y1W = S1 - FB;
	localparam int P2  = Y1W + TRIG_WIDTH;
	localparam int S2  = P2 + 1;
	localparam int RW  = S2 - FB;
	localparam logic signed [S1-1:0] RND1 = S1'(1) << (FB - 1);
	localparam logic signed [S2-1:0] RND2 = S2'(1) << (FB - 1);

	logic v_s1, v_s2, v_s3;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic signed [COORD_WIDTH-1:0] x_s2, y_s2, z_s2;
	logic signed [COORD_WIDTH-1:0] x_s3, y_s3, z_s3;
	logic last_s1, last_s2, last_s3;
	logic signed [P1-1:0] ycx_s1, zsx_s1, ysx_s1, zcx_s1;
	logic signed [Y1W-1:0] y1_s2, z1_s2, y1_s3;
	logic signed [P2-1:0] z1sy_s3, xcy_s3, z1cy_s3, xsy_s3;

	logic signed [S1-1:0] sum_y1, sum_z1;
	logic signed [S2-1:0] sum_x2, sum_z2;
	logic signed [RW-1:0] x2_full, z2_full;
	logic signed [COORD_WIDTH-1:0] x2_sat, y1_sat, z2_sat;

	always_comb begin
		sum_y1 = S1'(ycx_s1) - S1'(zsx_s1) + RND1;
		sum_z1 = S1'(ysx_s1) + S1'(zcx_s1) + RND1;
		sum_x2 = S2'(z1sy_s3) + S2'(xcy_s3) + RND2;
		sum_z2 = S2'(z1cy_s3) - S2'(xsy_s3) + RND2;
		x2_full = RW'(sum_x2 >>> FB);
		z2_full = RW'(sum_z2 >>> FB);
		x2_sat = (x2_full[RW-1:COORD_WIDTH-1] == {(RW - COORD_WIDTH + 1){x2_full[RW-1]}})
			? x2_full[COORD_WIDTH-1:0]
			: {x2_full[RW-1], {(COORD_WIDTH - 1){~x2_full[RW-1]}}};
		z2_sat = (z2_full[RW-1:COORD_WIDTH-1] == {(RW - COORD_WIDTH + 1){z2_full[RW-1]}})
			? z2_full[COORD_WIDTH-1:0]
			: {z2_full[RW-1], {(COORD_WIDTH - 1){~z2_full[RW-1]}}};
		y1_sat = (y1_s3[Y1W-1:COORD_WIDTH-1] == {(Y1W - COORD_WIDTH + 1){y1_s3[Y1W-1]}})
			? y1_s3[COORD_WIDTH-1:0]
			: {y1_s3[Y1W-1], {(COORD_WIDTH - 1){~y1_s3[Y1W-1]}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= in_x;
		y_s1 <= in_y;
		z_s1 <= in_z;
		last_s1 <= in_last;
		ycx_s1 <= P1'(in_y) * P1'(cos_x);
		zsx_s1 <= P1'(in_z) * P1'(sin_x);
		ysx_s1 <= P1'(in_y) * P1'(sin_x);
		zcx_s1 <= P1'(in_z) * P1'(cos_x);

		x_s2 <= x_s1;
		y_s2 <= y_s1;
		z_s2 <= z_s1;
		last_s2 <= last_s1;
		y1_s2 <= Y1W'(sum_y1 >>> FB);
		z1_s2 <= Y1W'(sum_z1 >>> FB);

		x_s3 <= x_s2;
		y_s3 <= y_s2;
		z_s3 <= z_s2;
		last_s3 <= last_s2;
		y1_s3 <= y1_s2;
		z1sy_s3 <= P2'(z1_s2) * P2'(sin_y);
		xcy_s3 <= P2'(x_s2) * P2'(cos_y);
		z1cy_s3 <= P2'(z1_s2) * P2'(cos_y);
		xsy_s3 <= P2'(x_s2) * P2'(sin_y);

		out_x <= rotate_en ? x2_sat : x_s3;
		out_y <= rotate_en ? y1_sat : y_s3;
		out_z <= rotate_en ? z2_sat : z_s3;
		out_last <= last_s3;
	end

endmodule

// ----- hdl/vertex_two_axis_rotator.sv -----
// Top level of the two-axis vertex rotator.
// Rotates each vertex about X by angle_about_x, then about Y by angle_about_y.
// Channels: vertex (sink) carries coord_x/y/z and object_last; result (source)
// carries rot_x/y/z and object_last_out. A beat moves when valid and ready are high.
// Configuration: cfg_we with cfg_index 0 (angle about X), 1 (angle about Y),
// 2 (rotate enable); other indexes are ignored. Angles are binary, 32768 = pi.
// Throughput: one vertex per cycle while vertex.ready is high. An accepted vertex
// beat reaches result.valid through the four datapath stages and the output queue.
// Sines and cosines come from a 30-cell CORDIC chain fed by the angle
// registers; after reset and after every configuration write, vertex.ready
// stays low while the chain refills.
// Results land in an 8-entry output queue; vertex.ready drops once 8 vertices
// are in flight or queued, so a stalled receiver loses nothing.
// Reset clears the angles, sets rotate enable and empties the queue.
module vertex_two_axis_rotator #(
	parameter int COORD_WIDTH = 16,
	parameter int TRIG_WIDTH  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [vtr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [vtr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	vtr_vertex_if.sink                            vertex,
	vtr_result_if.source                          result
);
	import vtr_pkg::*;

	logic signed [ANGLE_WIDTH-1:0] angle_x_q, angle_y_q;
	logic rotate_en_q;
	logic [TRIG_WAIT_WIDTH-1:0] trig_wait_q;

	logic signed [TRIG_WIDTH-1:0] cos_x, sin_x, cos_y, sin_y;

	logic accept, pop;
	logic pipe_valid, pipe_last;
	logic signed [COORD_WIDTH-1:0] pipe_x, pipe_y, pipe_z;

	logic signed [COORD_WIDTH-1:0] mem_x [FIFO_DEPTH];
	logic signed [COORD_WIDTH-1:0] mem_y [FIFO_DEPTH];
	logic signed [COORD_WIDTH-1:0] mem_z [FIFO_DEPTH];
	logic                          mem_last [FIFO_DEPTH];
	logic [FIFO_PTR_WIDTH-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_WIDTH-1:0] fifo_cnt_q, occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_x_q <= '0;
			angle_y_q <= '0;
			rotate_en_q <= 1'b1;
			trig_wait_q <= TRIG_WAIT_WIDTH'(TRIG_LATENCY);
		end else begin
			if (cfg_we) begin
				trig_wait_q <= TRIG_WAIT_WIDTH'(TRIG_LATENCY);
				unique case (cfg_index)
					REG_ANGLE_X:   angle_x_q <= cfg_data;
					REG_ANGLE_Y:   angle_y_q <= cfg_data;
					REG_ROTATE_EN: rotate_en_q <= cfg_data[0];
					default: ;
				endcase
			end else if (trig_wait_q != '0) begin
				trig_wait_q <= trig_wait_q - 1'b1;
			end
		end
	end

	vtr_trig_chain #(.TRIG_WIDTH(TRIG_WIDTH)) u_trig (
		.clk     (clk),
		.angle_x (angle_x_q),
		.angle_y (angle_y_q),
		.cos_x   (cos_x),
		.sin_x   (sin_x),
		.cos_y   (cos_y),
		.sin_y   (sin_y)
	);

	assign vertex.ready = (trig_wait_q == '0) && (occ_q < FIFO_CNT_WIDTH'(FIFO_DEPTH));
	assign accept = vertex.valid && vertex.ready;
	assign pop = result.valid && result.ready;

	vtr_vertex_pipe #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_x      (vertex.coord_x),
		.in_y      (vertex.coord_y),
		.in_z      (vertex.coord_z),
		.in_last   (vertex.object_last),
		.cos_x     (cos_x),
		.sin_x     (sin_x),
		.cos_y     (cos_y),
		.sin_y     (sin_y),
		.rotate_en (rotate_en_q),
		.out_valid (pipe_valid),
		.out_x     (pipe_x),
		.out_y     (pipe_y),
		.out_z     (pipe_z),
		.out_last  (pipe_last)
	);

	always_ff @(posedge clk) begin
		if (pipe_valid) begin
			mem_x[wr_ptr_q] <= pipe_x;
			mem_y[wr_ptr_q] <= pipe_y;
			mem_z[wr_ptr_q] <= pipe_z;
			mem_last[wr_ptr_q] <= pipe_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fifo_cnt_q <= '0;
			occ_q <= '0;
		end else begin
			if (pipe_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_WIDTH'(pipe_valid) - FIFO_CNT_WIDTH'(pop);
			occ_q <= occ_q + FIFO_CNT_WIDTH'(accept) - FIFO_CNT_WIDTH'(pop);
		end
	end

	assign result.valid = (fifo_cnt_q != '0);
	assign result.rot_x = mem_x[rd_ptr_q];
	assign result.rot_y = mem_y[rd_ptr_q];
	assign result.rot_z = mem_z[rd_ptr_q];
	assign result.object_last_out = mem_last[rd_ptr_q];

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FIFO_CNT_WIDTH'(FIFO_DEPTH))
		else $error("in-flight count above queue depth");

	a_queue_within_occ: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= occ_q)
		else $error("queue holds more beats than were accepted");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_valid |-> (fifo_cnt_q < FIFO_CNT_WIDTH'(FIFO_DEPTH)) || pop)
		else $error("result written into a full queue");

	a_trig_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !vertex.ready)
		else $error("vertex accepted before sine and cosine settle");
`endif

endmodule
